// ===== design/nvf_local_variance_mask_unit_defines.svh =====
// Assertion macros used by the port-level checker
`ifndef NVF_LOCAL_VARIANCE_MASK_UNIT_DEFINES_SVH
`define NVF_LOCAL_VARIANCE_MASK_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define NVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nvf check failed");
// next-cycle implication
`define NVF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nvf check failed");
`endif

// ===== design/nvf_pkg.sv =====
// Shared constants, types and helpers of the NVF mask block
package nvf_pkg;
    localparam int WINDOW_DEF   = 3;
    localparam int MAX_COLS_DEF = 1024;
    localparam int ROWS_LIMIT   = 4096;
    localparam int COLS_W       = 11;
    localparam int ROWS_W       = 13;
    localparam int PIX_W        = 8;
    localparam int MASK_W       = 16;
    localparam int DIV_STEPS    = 16;
    localparam int QDEPTH       = 4;
    localparam logic [0:0] CFG_COLS = 1'b0;
    localparam logic [0:0] CFG_ROWS = 1'b1;

    // work item passed from the front end through the queue to the divider
    typedef struct packed {
        logic [31:0] num;
        logic        last;
    } t_work;
endpackage

// ===== design/nvf_front.sv =====
// Front end: line stores, window, sums, numerator of the mask
module nvf_front #(
    parameter int WINDOW   = nvf_pkg::WINDOW_DEF,
    parameter int MAX_COLS = nvf_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [nvf_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_frame_start,
    input  logic [nvf_pkg::COLS_W-1:0] i_cols,
    input  logic [nvf_pkg::ROWS_W-1:0] i_rows,
    output logic                       o_valid,
    output nvf_pkg::t_work             o_work
);
    localparam int PAD   = WINDOW / 2;
    localparam int LINES = WINDOW - 1;
    localparam int LIW   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LLEN  = MAX_COLS + 2 * PAD;
    localparam int AW    = $clog2(LLEN);
    localparam int CW    = $clog2(MAX_COLS + 2 * PAD + 1);
    localparam int RW    = nvf_pkg::ROWS_W + 1;
    localparam int NN    = WINDOW * WINDOW;
    localparam int SW    = $clog2(NN * 255 + 1);
    localparam int QW    = $clog2(NN * 65025 + 1);

    // effective sizes after clamping
    logic [CW-1:0] w_pw;
    logic [RW-1:0] w_ph;
    always_comb begin
        if (i_cols == '0) w_pw = CW'(1 + 2 * PAD);
        else if (32'(i_cols) > MAX_COLS) w_pw = CW'(MAX_COLS + 2 * PAD);
        else w_pw = CW'(i_cols) + CW'(2 * PAD);
        if (i_rows == '0) w_ph = RW'(1 + 2 * PAD);
        else if (32'(i_rows) > nvf_pkg::ROWS_LIMIT)
            w_ph = RW'(nvf_pkg::ROWS_LIMIT + 2 * PAD);
        else w_ph = RW'(i_rows) + RW'(2 * PAD);
    end

    // position of this pixel
    logic [CW-1:0] r_col, n_col, w_col;
    logic [RW-1:0] r_row, n_row, w_row;
    logic [$clog2(LINES+1)-1:0] r_lsel, w_lsel;
    always_comb begin
        w_col = i_frame_start ? '0 : r_col;
        w_row = i_frame_start ? '0 : r_row;
        w_lsel = i_frame_start ? '0 : r_lsel;
        if (w_col >= w_pw) begin
            w_col = '0;
            w_row = w_row + 1'b1;
            w_lsel = (32'(w_lsel) == LINES - 1) ? '0 : w_lsel + 1'b1;
        end
        if (w_row >= w_ph) begin
            w_row = '0;
            w_lsel = '0;
        end
        n_col = w_col + 1'b1;
        n_row = w_row;
    end

    // line memories, one per stored row
    logic [nvf_pkg::PIX_W-1:0] r_mem [LINES][LLEN];
    logic [nvf_pkg::PIX_W-1:0] r_rd  [LINES];
    logic [AW-1:0] w_addr;
    assign w_addr = w_col[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            for (int k = 0; k < LINES; k++) begin
                r_rd[k] <= r_mem[k][w_addr];
                if (32'(w_lsel) == k) r_mem[k][w_addr] <= i_pixel;
            end
        end
    end

    // stage 1 registers
    logic                      r_v1, r_emit1, r_last1;
    logic [nvf_pkg::PIX_W-1:0] r_pix1;
    logic [$clog2(LINES+1)-1:0] r_lsel1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_lsel <= '0; r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            if (i_take) begin
                r_col <= n_col; r_row <= n_row; r_lsel <= w_lsel;
            end
        end
        if (i_take) begin
            r_pix1  <= i_pixel;
            r_lsel1 <= w_lsel;
            r_emit1 <= (32'(w_row) >= WINDOW - 1) && (32'(w_col) >= WINDOW - 1);
            r_last1 <= (w_row == w_ph - 1'b1) && (w_col == w_pw - 1'b1);
        end
    end

    // column: oldest row first; slot (row+k) wrapped at LINES
    logic [nvf_pkg::PIX_W-1:0] w_colv [WINDOW];
    always_comb begin
        int t;
        for (int k = 0; k < LINES; k++) begin
            t = 32'(r_lsel1) + k;
            if (t >= LINES) t = t - LINES;
            w_colv[k] = r_rd[t[LIW-1:0]];
        end
        w_colv[WINDOW-1] = r_pix1;
    end

    // window shift register
    logic [nvf_pkg::PIX_W-1:0] r_win [WINDOW][WINDOW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++)
                for (int j = 0; j < WINDOW; j++) r_win[i][j] <= '0;
        end else if (r_v1) begin
            for (int i = 0; i < WINDOW; i++) begin
                for (int j = 0; j < WINDOW - 1; j++) r_win[i][j] <= r_win[i][j+1];
                r_win[i][WINDOW-1] <= w_colv[i];
            end
        end
    end

    // stage 2: window now holds item's neighborhood
    logic r_v2, r_last2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1 && r_emit1;
        r_last2 <= r_last1;
    end

    // per-row sums, registered
    logic [SW-1:0] w_rs [WINDOW];
    logic [QW-1:0] w_rq [WINDOW];
    logic [SW-1:0] r_rs [WINDOW];
    logic [QW-1:0] r_rq [WINDOW];
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            w_rs[i] = '0; w_rq[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                w_rs[i] = w_rs[i] + SW'(r_win[i][j]);
                w_rq[i] = w_rq[i] + QW'(r_win[i][j]) * QW'(r_win[i][j]);
            end
        end
    end
    logic r_v3, r_last3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_v2;
        r_last3 <= r_last2;
        for (int i = 0; i < WINDOW; i++) begin
            r_rs[i] <= w_rs[i]; r_rq[i] <= w_rq[i];
        end
    end

    // total sums
    logic [SW-1:0] w_s;
    logic [QW-1:0] w_q;
    always_comb begin
        w_s = '0; w_q = '0;
        for (int i = 0; i < WINDOW; i++) begin
            w_s = w_s + r_rs[i]; w_q = w_q + r_rq[i];
        end
    end
    logic [SW-1:0] r_s;
    logic [QW-1:0] r_q;
    logic r_v4, r_last4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else r_v4 <= r_v3;
        r_last4 <= r_last3;
        r_s <= w_s; r_q <= w_q;
    end

    // products, then difference
    logic [31:0] r_nq, r_ss;
    logic r_v5, r_last5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else r_v5 <= r_v4;
        r_last5 <= r_last4;
        r_nq <= 32'(r_q) * 32'(NN);
        r_ss <= 32'(r_s) * 32'(r_s);
    end
    assign o_valid     = r_v5;
    assign o_work.num  = r_nq - r_ss;
    assign o_work.last = r_last5;
endmodule

// ===== design/nvf_queue.sv =====
// Short FIFO between front end and divider
module nvf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nvf_pkg::t_work i_data,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_room,
    output nvf_pkg::t_work o_data
);
    localparam int AW = $clog2(nvf_pkg::QDEPTH);
    nvf_pkg::t_work r_buf [nvf_pkg::QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_data;
    end
    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
    assign o_empty = (r_cnt == '0);
    assign o_room  = (r_cnt != (AW+1)'(nvf_pkg::QDEPTH));
    assign o_data  = r_buf[r_rp];
endmodule

// ===== design/nvf_back.sv =====
// Back end: restoring divider and output register
module nvf_back #(
    parameter int WINDOW = nvf_pkg::WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  nvf_pkg::t_work             i_work,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [nvf_pkg::MASK_W-1:0] o_mask,
    output logic                       o_last
);
    localparam int NN = WINDOW * WINDOW;
    localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;
    localparam int KW = $clog2(nvf_pkg::DIV_STEPS + 1);

    logic [1:0]  r_st;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [nvf_pkg::MASK_W-1:0] r_quo;
    logic [KW-1:0] r_k;
    logic r_last;
    logic [32:0] w_sh;

    assign w_sh  = {r_rem[31:0], 1'b0};
    assign o_pop = (r_st == S_IDLE) && i_avail;

    // one quotient bit per cycle: (num<<16)/(num+NN(NN-1)), NN = WINDOW*WINDOW
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_avail) begin
                    r_rem  <= {1'b0, i_work.num};
                    r_den  <= i_work.num + 32'(NN * (NN - 1));
                    r_last <= i_work.last;
                    r_k    <= '0;
                    r_st   <= S_DIV;
                end
                S_DIV: begin
                    if (w_sh >= {1'b0, r_den}) begin
                        r_rem <= w_sh - {1'b0, r_den};
                        r_quo <= {r_quo[nvf_pkg::MASK_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_quo <= {r_quo[nvf_pkg::MASK_W-2:0], 1'b0};
                    end
                    r_k <= r_k + 1'b1;
                    if (32'(r_k) == nvf_pkg::DIV_STEPS - 1) r_st <= S_OUT;
                end
                S_OUT: if (i_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign o_tvalid = (r_st == S_OUT);
    assign o_mask   = r_quo;
    assign o_last   = r_last;
endmodule

// ===== design/nvf_local_variance_mask_unit.sv =====
// Top level of the NVF local variance mask block
// Takes one padded pixel per accepted beat; every pixel that completes a window yields one
// mask beat. The front end holds one pixel at a time in its five-stage pipeline, so a new
// input beat waits until a busy counter runs down. A mask leaving the front end waits in a
// four-entry queue; the divider then pops it, develops the 16-bit quotient one bit at a time
// and holds it in an output state until the receiver takes it, so it works on one mask at a
// time. Besides the busy counter, the input stalls only when the queue has no room, so output
// back-pressure fills the queue before it stops the input. Line stores cover MAX_COLS plus
// padding; contents need no clearing after reset.
module nvf_local_variance_mask_unit #(
    parameter int WINDOW   = nvf_pkg::WINDOW_DEF,
    parameter int MAX_COLS = nvf_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] mask
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [nvf_pkg::COLS_W-1:0] r_cols;
    logic [nvf_pkg::ROWS_W-1:0] r_rows;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= nvf_pkg::COLS_W'(512);
            r_rows <= nvf_pkg::ROWS_W'(512);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nvf_pkg::CFG_COLS: r_cols <= i_cfg_data[nvf_pkg::COLS_W-1:0];
                nvf_pkg::CFG_ROWS: r_rows <= i_cfg_data[nvf_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // one pixel in flight at a time through the front pipeline
    logic [2:0] r_busy;
    logic w_take, w_fv, w_empty, w_room, w_pop;
    nvf_pkg::t_work w_fw, w_qd;
    assign s_axis_tready = (r_busy == '0) && w_room;
    assign w_take = s_axis_tvalid && s_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= '0;
        else if (w_take) r_busy <= 3'd5;
        else if (r_busy != '0) r_busy <= r_busy - 1'b1;
    end

    nvf_front #(.WINDOW(WINDOW), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_pixel(s_axis_tdata),
        .i_frame_start(s_axis_tuser), .i_cols(r_cols), .i_rows(r_rows),
        .o_valid(w_fv), .o_work(w_fw)
    );
    nvf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_fv), .i_data(w_fw), .i_pop(w_pop),
        .o_empty(w_empty), .o_room(w_room), .o_data(w_qd)
    );
    nvf_back #(.WINDOW(WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_avail(!w_empty), .i_work(w_qd),
        .o_pop(w_pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_mask(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

// ===== design/nvf_checker.sv =====
// Port-level checker for the NVF mask block, bound to the top level
`include "nvf_local_variance_mask_unit_defines.svh"
module nvf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic w_out_wait, w_in_take;
    assign w_out_wait = m_axis_tvalid && !m_axis_tready;
    assign w_in_take  = s_axis_tvalid && s_axis_tready;

    `NVF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `NVF_ASSERT_NXT(a_last_hold, i_clk, i_rst_n, w_out_wait, $stable(m_axis_tlast))
    `NVF_ASSERT_NXT(a_gap_after_take, i_clk, i_rst_n, w_in_take, !s_axis_tready)
endmodule

bind nvf_local_variance_mask_unit nvf_checker u_nvf_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// ===== tb/sv/nvf_mask_checker.sv =====
// Mask stream checker: predicts NVF mask beats from accepted pixels and compares them
`timescale 1ns / 1ps
module nvf_mask_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [7:0]  i_pix_data,
    input  logic        i_pix_start,
    input  logic        i_mask_valid,
    input  logic        i_mask_ready,
    input  logic [15:0] i_mask_data,
    input  logic        i_mask_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int WIN  = nvf_pkg::WINDOW_DEF;
    localparam int PADW = WIN / 2;
    localparam int LLEN = nvf_pkg::MAX_COLS_DEF + 2 * PADW;

    typedef struct packed {
        logic [15:0] mask;
        logic        last;
    } t_mask_beat;

    logic [7:0]  line_mem [WIN-1][LLEN];
    logic [7:0]  win_pix [WIN][WIN];
    int unsigned col_pos, row_pos;
    logic [10:0] cols_reg;
    logic [12:0] rows_reg;
    t_mask_beat  mask_q [$];

    assign o_pending = mask_q.size();

    // advance the window model by one pixel; push a mask beat when a window completes
    task automatic predict_pixel(input logic [7:0] pix, input logic start);
        int unsigned pw, ph, c, r, ec, er;
        logic [7:0] colv [WIN];
        longint unsigned s, q, num, den, m, v;
        t_mask_beat b;
        ec = (cols_reg == 0) ? 1 : (cols_reg > nvf_pkg::MAX_COLS_DEF) ?
             nvf_pkg::MAX_COLS_DEF : cols_reg;
        er = (rows_reg == 0) ? 1 : (rows_reg > nvf_pkg::ROWS_LIMIT) ?
             nvf_pkg::ROWS_LIMIT : rows_reg;
        pw = ec + 2 * PADW;
        ph = er + 2 * PADW;
        if (start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= pw) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= ph) row_pos = 0;
        c = col_pos;
        r = row_pos;
        for (int k = 0; k < WIN - 1; k++) colv[k] = line_mem[(r + k) % (WIN - 1)][c];
        colv[WIN-1] = pix;
        line_mem[r % (WIN - 1)][c] = pix;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) win_pix[i][j] = win_pix[i][j+1];
            win_pix[i][WIN-1] = colv[i];
        end
        if (r >= WIN - 1 && c >= WIN - 1) begin
            s = 0;
            q = 0;
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN; j++) begin
                    v = win_pix[i][j];
                    s += v;
                    q += v * v;
                end
            num = WIN * WIN * q - s * s;
            den = num + WIN * WIN * (WIN * WIN - 1);
            m = (num << 16) / den;
            if (m > 65535) m = 65535;
            b.mask = m[15:0];
            b.last = (r == ph - 1 && c == pw - 1);
            mask_q.push_back(b);
        end
        col_pos = c + 1;
    endtask

    always @(posedge i_clk) begin
        t_mask_beat exp_b;
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN; j++) win_pix[i][j] = '0;
            for (int i = 0; i < WIN - 1; i++)
                for (int j = 0; j < LLEN; j++) line_mem[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
            cols_reg = 11'd512;
            rows_reg = 13'd512;
            mask_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == nvf_pkg::CFG_COLS) cols_reg = i_cfg_data[10:0];
                else rows_reg = i_cfg_data[12:0];
            end
            // compare the output beat before adding this edge's prediction
            if (i_mask_valid && i_mask_ready) begin
                if (mask_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected mask beat: mask=%0d last=%0b",
                                 i_mask_data, i_mask_last);
                end else begin
                    exp_b = mask_q.pop_front();
                    if (exp_b.mask !== i_mask_data || exp_b.last !== i_mask_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mask mismatch: exp mask=%0d last=%0b got mask=%0d last=%0b",
                                     exp_b.mask, exp_b.last, i_mask_data, i_mask_last);
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pix_data, i_pix_start);
        end
    end
endmodule

// ===== tb/sv/tb_nvf_local_variance_mask_unit.sv =====
// Testbench top: drives pixel frames and register writes into the NVF mask block
`timescale 1ns / 1ps
module tb_nvf_local_variance_mask_unit;
    localparam int WIN   = nvf_pkg::WINDOW_DEF;
    localparam int PADW  = WIN / 2;
    localparam int LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = nvf_pkg::CFG_COLS;
    logic [31:0] i_cfg_data = '0;

    int  fail_count, pending;
    int  pixels_sent = 0;
    int  idle_cycles = 0;
    bit  hold_sink = 0;
    bit  hold_taken = 0;
    int  cur_cols = 512, cur_rows = 512;

    always #5 i_clk = ~i_clk;

    nvf_local_variance_mask_unit uut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    nvf_mask_checker chk (
        .i_clk, .i_rst_n,
        .i_pix_valid(s_axis_tvalid), .i_pix_ready(s_axis_tready),
        .i_pix_data(s_axis_tdata), .i_pix_start(s_axis_tuser),
        .i_mask_valid(m_axis_tvalid), .i_mask_ready(m_axis_tready),
        .i_mask_data(m_axis_tdata), .i_mask_last(m_axis_tlast),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // send one pixel beat after a random gap; valid drops only during a gap
    task automatic send_pixel(input logic [7:0] pix, input logic start, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for all masks, then let trailing non-emitting pixels drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // pixel content modes: 0 random, 1 flat, 2 extremes, 3 checker
    function automatic logic [7:0] pick_pixel(int mode, int r, int c);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return 8'd200;
            2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return ((r + c) % 2 != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // full padded frame with zero border
    task automatic send_frame(input int mode, input bit mark_start, input bit no_gap);
        int pw, ph;
        logic [7:0] p;
        pw = cur_cols + 2 * PADW;
        ph = cur_rows + 2 * PADW;
        for (int r = 0; r < ph; r++)
            for (int c = 0; c < pw; c++) begin
                p = (r < PADW || r >= ph - PADW || c < PADW || c >= pw - PADW) ? 8'd0
                    : pick_pixel(mode, r, c);
                send_pixel(p, mark_start && r == 0 && c == 0, no_gap);
            end
    endtask

    task automatic set_size(input int cols, input int rows, input int raw_c, input int raw_r);
        wait_idle();
        write_reg(nvf_pkg::CFG_COLS, raw_c);
        write_reg(nvf_pkg::CFG_ROWS, raw_r);
        cur_cols = cols;
        cur_rows = rows;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink && !hold_taken) begin
                hold_taken = 1;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    // watchdog on accepted beats of any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiny frames covering extremes and register clamps
        set_size(2, 2, 2, 2);
        send_frame(2, 1, 0);
        send_frame(1, 0, 0);       // next frame starts by wraparound
        set_size(1, 1, 0, 0);      // zero acts as one
        send_frame(2, 1, 1);
        send_frame(3, 1, 0);
        // frame_start in the middle of a frame restarts it
        set_size(3, 2, 3, 2);
        for (int i = 0; i < 4; i++) send_pixel(8'hFF, i == 0, 0);
        send_frame(3, 1, 0);
        wait_idle();
        set_size(1, 4096, 1, 8191);  // row clamp, one column wide
        for (int i = 0; i < 60; i++)
            send_pixel((i % 3 == 1 && i > 3) ? 8'($urandom_range(0, 255)) : 8'd0, i == 0, 0);
        set_size(2, 2, 2, 2);

        // long receiver stall while pixels keep flowing
        hold_sink = 1;
        send_frame(0, 1, 1);
        send_frame(0, 1, 1);
        wait_idle();

        // random frames of small sizes, with some noise pixels between them
        while (pixels_sent < 1300) begin
            int rc, rr;
            rc = $urandom_range(1, 6);
            rr = $urandom_range(1, 5);
            set_size(rc, rr, rc, rr);
            for (int f = 0; f < $urandom_range(1, 3); f++) begin
                if ($urandom_range(0, 7) == 0)
                    for (int i = 0; i < $urandom_range(1, 5); i++)
                        send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
                send_frame($urandom_range(0, 3), 1, $urandom_range(0, 3) == 0);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== nvf_local_variance_mask_unit.f =====
+incdir+design
design/nvf_pkg.sv
design/nvf_front.sv
design/nvf_queue.sv
design/nvf_back.sv
design/nvf_local_variance_mask_unit.sv
design/nvf_checker.sv
tb/sv/nvf_mask_checker.sv
tb/sv/tb_nvf_local_variance_mask_unit.sv
